/* hdl/htp_pkg.sv */
// Shared types, constants and elaboration-time helpers of the hopping probability block.
package htp_pkg;

  localparam int unsigned MAX_DIMS = 3;
  localparam int unsigned CFG_W = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [17:0] PI_Q = 18'd205887;
  localparam logic [16:0] LOG2E_Q = 17'd94548;

  localparam logic [31:0] TAU_RESET = 32'h0001_0000;
  localparam logic [31:0] EPS_RESET = 32'h0001_0000;
  localparam logic [31:0] ALPHA_RESET = 32'h0001_0000;
  localparam logic [1:0] DIMS_RESET = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAU        = 3'd0,
    CFG_EPS        = 3'd1,
    CFG_ALPHA      = 3'd2,
    CFG_APPROX_TAU = 3'd3,
    CFG_APPROX_EXP = 3'd4,
    CFG_DROP_PREF  = 3'd5,
    CFG_DIMS       = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEG_RAD  = 2'd1,
    ST_ZERO_MOM = 2'd2,
    ST_ZERO_GAP = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] momentum_z;
    logic [31:0]        gap;
    logic               upper_level;
  } in_t;

  typedef struct packed {
    logic [23:0] probability;
    logic [1:0]  status;
  } out_t;

  function automatic logic [31:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bv;
    int i;
    rem = v;
    res = '0;
    bv = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (rem >= res + bv) begin
        rem = rem - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res[31:0];
  endfunction

  // Factor 2^(-2^-idx) in Q0.32, each one the floored root of the one before.
  function automatic logic [31:0] exp_factor(input int unsigned idx);
    logic [63:0] c;
    int unsigned k;
    c = 64'd1 << 31;
    for (k = 1; k <= idx; k++) begin
      c = {32'b0, isqrt64({c[31:0], 32'b0})};
    end
    return c[31:0];
  endfunction

endpackage

/* hdl/htp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
module htp_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32,
  parameter int unsigned QB = 32,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QB-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned HW = NW - QB;
  localparam int unsigned CW = (HW > DW) ? HW : DW;

  logic          v_q    [QB+1];
  logic [DW-1:0] rem_q  [QB+1];
  logic [QB-1:0] nq_q   [QB+1];
  logic [DW-1:0] den_q  [QB+1];
  logic          sat_q  [QB+1];
  logic [SW-1:0] side_q [QB+1];

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;
  logic          sat_d;

  assign hi_ext = CW'(num_i[NW-1:QB]);
  assign den_ext = CW'(den_i);
  assign sat_d = (hi_ext >= den_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= sat_d ? '0 : hi_ext[DW-1:0];
      nq_q[0]   <= num_i[QB-1:0];
      den_q[0]  <= den_i;
      sat_q[0]  <= sat_d;
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        take;

    assign trial = {rem_q[s], nq_q[s][QB-1]};
    assign diff = trial - {1'b0, den_q[s]};
    assign take = (trial >= {1'b0, den_q[s]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= take ? diff[DW-1:0] : trial[DW-1:0];
        nq_q[s+1]   <= {nq_q[s][QB-2:0], take};
        den_q[s+1]  <= den_q[s];
        sat_q[s+1]  <= sat_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign valid_o = v_q[QB];
  assign quot_o = sat_q[QB] ? '1 : nq_q[QB];
  assign side_o = side_q[QB];

endmodule

/* hdl/htp_sqrt.sv */
// Two-lane pipelined integer square root of 64-bit values, one root bit per stage.
module htp_sqrt #(
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [63:0]   rad_a_i,
  input  logic [63:0]   rad_b_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [31:0]   root_a_o,
  output logic [31:0]   root_b_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned NS = 32;

  logic          v_q    [NS+1];
  logic [63:0]   rad_q  [NS+1][2];
  logic [33:0]   rem_q  [NS+1][2];
  logic [31:0]   root_q [NS+1][2];
  logic [SW-1:0] side_q [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0][0]  <= rad_a_i;
      rad_q[0][1]  <= rad_b_i;
      rem_q[0][0]  <= '0;
      rem_q[0][1]  <= '0;
      root_q[0][0] <= '0;
      root_q[0][1] <= '0;
      side_q[0]    <= side_i;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else if (en_i) begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s+1] <= side_q[s];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [35:0] cur;
      logic [35:0] trial;
      logic [35:0] diff;
      logic        take;

      assign cur = {rem_q[s][l], rad_q[s][l][63:62]};
      assign trial = {2'b00, root_q[s][l], 2'b01};
      assign diff = cur - trial;
      assign take = (cur >= trial);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[s+1][l]  <= {rad_q[s][l][61:0], 2'b00};
          rem_q[s+1][l]  <= take ? diff[33:0] : cur[33:0];
          root_q[s+1][l] <= {root_q[s][l][30:0], take};
        end
      end
    end
  end

  assign valid_o = v_q[NS];
  assign root_a_o = root_q[NS][0];
  assign root_b_o = root_q[NS][1];
  assign side_o = side_q[NS];

endmodule

/* hdl/hopping_transition_probability_top.sv */
// Top level of the pipelined surface-hopping transition probability block.
//
// Requests enter on in_data_i with in_valid_i and leave on out_data_o with out_valid_o.
// A request is taken at a clock edge where its valid is high and its stall is low.
// The block accepts a request every unstalled cycle and returns one result per request, in order.
// The path from request to result runs through a chain of bit-serial stages:
// the two square roots, the tau, exponent-argument and prefactor dividers,
// the exponent divider and the sixteen factor stages of the exponential.
// When out_stall_i holds a waiting result, the whole pipeline holds and in_stall_o rises.
// Configuration registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i; unknown
// indexes are ignored. The user must write them only while no request is in flight;
// the block does not enforce this. Reset clears all valid bits and returns the registers
// to tau, epsilon and alpha of 1.0, all modes off and one momentum component.
module hopping_transition_probability_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  htp_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output htp_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [htp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [htp_pkg::CFG_W-1:0]      cfg_wdata_i
);

  typedef struct packed {
    logic [31:0] g;
    logic [1:0]  st;
    logic [64:0] tnum;
  } sq_side_t;

  typedef struct packed {
    logic [31:0] g;
    logic [1:0]  st;
    logic [31:0] p;
    logic [31:0] k;
  } dt_side_t;

  typedef struct packed {
    logic [31:0] g;
    logic [1:0]  st;
    logic [31:0] p;
    logic [31:0] k;
    logic [31:0] t;
  } dd_side_t;

  typedef struct packed {
    logic [31:0] g;
    logic [1:0]  st;
    logic [31:0] t;
    logic [48:0] d;
  } dr_side_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [63:0] rr;
  } dx_side_t;

  // Configuration registers.
  logic [31:0] tau_q, eps_q, alpha_q;
  logic        approx_tau_q, approx_exp_q, drop_q;
  logic [1:0]  dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tau_q        <= htp_pkg::TAU_RESET;
      eps_q        <= htp_pkg::EPS_RESET;
      alpha_q      <= htp_pkg::ALPHA_RESET;
      approx_tau_q <= 1'b0;
      approx_exp_q <= 1'b0;
      drop_q       <= 1'b0;
      dims_q       <= htp_pkg::DIMS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        htp_pkg::CFG_TAU:        tau_q <= cfg_wdata_i;
        htp_pkg::CFG_EPS:        eps_q <= cfg_wdata_i;
        htp_pkg::CFG_ALPHA:      alpha_q <= cfg_wdata_i;
        htp_pkg::CFG_APPROX_TAU: approx_tau_q <= cfg_wdata_i[0];
        htp_pkg::CFG_APPROX_EXP: approx_exp_q <= cfg_wdata_i[0];
        htp_pkg::CFG_DROP_PREF:  drop_q <= cfg_wdata_i[0];
        htp_pkg::CFG_DIMS:       dims_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] eps_eff, alpha_eff;
  logic [1:0]  dims_eff;

  assign eps_eff = (eps_q == '0) ? 32'd1 : eps_q;
  assign alpha_eff = (alpha_q == '0) ? 32'd1 : alpha_q;
  assign dims_eff = (dims_q == 2'd0) ? 2'd1 :
                    ((dims_q > 2'(htp_pkg::MAX_DIMS)) ? 2'(htp_pkg::MAX_DIMS) : dims_q);

  // Global advance: the pipeline moves unless a finished result is held.
  logic adv;
  logic out_valid_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign adv = ~in_stall_o;

  // Stage 0: input register.
  logic         v0_q;
  htp_pkg::in_t in0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in0_q <= in_data_i;
    end
  end

  // Stage 1: squares of the momentum components and of the gap.
  logic [31:0] mom [3];
  logic [63:0] sq_d [3];
  logic [63:0] sq1_q [3];
  logic [63:0] gg_d, gg1_q;
  logic [31:0] g1_q;
  logic        up1_q, v1_q;

  assign mom[0] = in0_q.momentum_x;
  assign mom[1] = in0_q.momentum_y;
  assign mom[2] = in0_q.momentum_z;

  for (genvar i = 0; i < 3; i++) begin : g_comp
    logic [31:0] mag;
    assign mag = mom[i][31] ? (~mom[i] + 32'd1) : mom[i];
    assign sq_d[i] = (2'(i) < dims_eff) ? (mag * mag) : 64'd0;
  end

  assign gg_d = in0_q.gap * in0_q.gap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq1_q <= sq_d;
      gg1_q <= gg_d;
      g1_q  <= in0_q.gap;
      up1_q <= in0_q.upper_level;
    end
  end

  // Stage 2: norm squared, radicand, status and partial products of the approximate tau.
  logic [63:0] p2_d, q_d, rad_d;
  logic [1:0]  st2_d;
  logic [49:0] glo_d, ghi_d;
  logic [63:0] p2_2q, rad_2q;
  logic [1:0]  st_2q;
  logic [49:0] glo_2q, ghi_2q;
  logic [31:0] g_2q;
  logic        v2_q;

  assign p2_d = sq1_q[0] + sq1_q[1] + sq1_q[2];
  assign q_d = {14'b0, g1_q, 18'b0};
  assign rad_d = up1_q ? (p2_d + q_d) : (p2_d - q_d);
  assign glo_d = gg1_q[31:0] * htp_pkg::PI_Q;
  assign ghi_d = gg1_q[63:32] * htp_pkg::PI_Q;

  always_comb begin
    if (g1_q == '0) begin
      st2_d = htp_pkg::ST_ZERO_GAP;
    end else if (p2_d == '0) begin
      st2_d = htp_pkg::ST_ZERO_MOM;
    end else if (!up1_q && (p2_d < q_d)) begin
      st2_d = htp_pkg::ST_NEG_RAD;
    end else begin
      st2_d = htp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_2q  <= p2_d;
      rad_2q <= rad_d;
      st_2q  <= st2_d;
      glo_2q <= glo_d;
      ghi_2q <= ghi_d;
      g_2q   <= g1_q;
    end
  end

  // Stage 3: numerator of the approximate tau, scaled down by 2^17.
  logic [81:0] tsum_d;
  logic [64:0] tnum_3q;
  logic [63:0] p2_3q, rad_3q;
  logic [1:0]  st_3q;
  logic [31:0] g_3q;
  logic        v3_q;

  assign tsum_d = {ghi_2q, 32'b0} + 82'(glo_2q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tnum_3q <= tsum_d[81:17];
      p2_3q   <= p2_2q;
      rad_3q  <= rad_2q;
      st_3q   <= st_2q;
      g_3q    <= g_2q;
    end
  end

  // Square roots of the norm squared and of the radicand.
  sq_side_t    sq_side_in, sq_side_out;
  logic        sq_valid;
  logic [31:0] p_root, k_root;

  assign sq_side_in = '{g: g_3q, st: st_3q, tnum: tnum_3q};

  htp_sqrt #(
    .SW($bits(sq_side_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .rad_a_i (p2_3q),
    .rad_b_i (rad_3q),
    .side_i  (sq_side_in),
    .valid_o (sq_valid),
    .root_a_o(p_root),
    .root_b_o(k_root),
    .side_o  (sq_side_out)
  );

  // Approximate tau: floor(gap^2 * pi / (2 * alpha)) in Q16.16.
  dt_side_t    dt_side_in, dt_side_out;
  logic        dt_valid;
  logic [31:0] tq;

  assign dt_side_in = '{g: sq_side_out.g, st: sq_side_out.st, p: p_root, k: k_root};

  htp_div #(
    .NW(65),
    .DW(32),
    .QB(32),
    .SW($bits(dt_side_t))
  ) u_div_tau (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(sq_valid),
    .num_i  (sq_side_out.tnum),
    .den_i  (alpha_eff),
    .side_i (dt_side_in),
    .valid_o(dt_valid),
    .quot_o (tq),
    .side_o (dt_side_out)
  );

  // Approximate exponent argument: floor(2 * gap / p) in Q33.16.
  dd_side_t    dd_side_in, dd_side_out;
  logic        dd_valid;
  logic [48:0] dq;
  logic [31:0] t_sel;

  assign t_sel = approx_tau_q ? tq : tau_q;
  assign dd_side_in = '{g: dt_side_out.g, st: dt_side_out.st, p: dt_side_out.p,
                        k: dt_side_out.k, t: t_sel};

  htp_div #(
    .NW(50),
    .DW(32),
    .QB(49),
    .SW($bits(dd_side_t))
  ) u_div_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(dt_valid),
    .num_i  ({1'b0, dt_side_out.g, 17'b0}),
    .den_i  (dt_side_out.p),
    .side_i (dd_side_in),
    .valid_o(dd_valid),
    .quot_o (dq),
    .side_o (dd_side_out)
  );

  // Prefactor root: floor((k + p) / (2p)) in Q16.16.
  dr_side_t    dr_side_in, dr_side_out;
  logic        dr_valid;
  logic [31:0] rq;
  logic [31:0] kp_diff;
  logic [32:0] kp_sum;
  logic [48:0] d_sel;

  assign kp_diff = (dd_side_out.k > dd_side_out.p) ? (dd_side_out.k - dd_side_out.p)
                                                   : (dd_side_out.p - dd_side_out.k);
  assign kp_sum = {1'b0, dd_side_out.k} + {1'b0, dd_side_out.p};
  assign d_sel = approx_exp_q ? dq : 49'(kp_diff);
  assign dr_side_in = '{g: dd_side_out.g, st: dd_side_out.st, t: dd_side_out.t, d: d_sel};

  htp_div #(
    .NW(48),
    .DW(32),
    .QB(32),
    .SW($bits(dr_side_t))
  ) u_div_pref (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(dd_valid),
    .num_i  ({kp_sum, 15'b0}),
    .den_i  (dd_side_out.p),
    .side_i (dr_side_in),
    .valid_o(dr_valid),
    .quot_o (rq),
    .side_o (dr_side_out)
  );

  // Stage 4: products for the exponent and the squared prefactor root.
  logic [63:0] tdlo_4q, ge_4q, rr_4q;
  logic [48:0] tdhi_4q;
  logic [1:0]  st_4q;
  logic        v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= dr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tdlo_4q <= dr_side_out.t * dr_side_out.d[31:0];
      tdhi_4q <= dr_side_out.t * dr_side_out.d[48:32];
      ge_4q   <= dr_side_out.g * eps_eff;
      rr_4q   <= rq * rq;
      st_4q   <= dr_side_out.st;
    end
  end

  // Exponent X = floor(tau * d * 2^16 / (gap * eps)), saturated.
  logic [80:0] td_sum;
  dx_side_t    dx_side_in, dx_side_out;
  logic        dx_valid;
  logic [31:0] xq;

  assign td_sum = {tdhi_4q, 32'b0} + 81'(tdlo_4q);
  assign dx_side_in = '{st: st_4q, rr: rr_4q};

  htp_div #(
    .NW(97),
    .DW(64),
    .QB(32),
    .SW($bits(dx_side_t))
  ) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(v4_q),
    .num_i  ({td_sum, 16'b0}),
    .den_i  (ge_4q),
    .side_i (dx_side_in),
    .valid_o(dx_valid),
    .quot_o (xq),
    .side_o (dx_side_out)
  );

  // Exponential: X * log2(e) split into integer and fraction, then one factor per stage.
  localparam int unsigned NF = 16;

  logic [48:0] y_d;
  logic        ev_q  [NF+1];
  logic [32:0] er_q  [NF+1];
  logic [15:0] ef_q  [NF+1];
  logic [16:0] en_q  [NF+1];
  logic [1:0]  est_q [NF+1];
  logic [63:0] err_q [NF+1];

  assign y_d = xq * htp_pkg::LOG2E_Q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q[0] <= 1'b0;
    end else if (adv) begin
      ev_q[0] <= dx_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      er_q[0]  <= 33'h1_0000_0000;
      ef_q[0]  <= y_d[31:16];
      en_q[0]  <= y_d[48:32];
      est_q[0] <= dx_side_out.st;
      err_q[0] <= dx_side_out.rr;
    end
  end

  for (genvar j = 1; j <= NF; j++) begin : g_fac
    localparam logic [31:0] Factor = htp_pkg::exp_factor(j);
    logic [64:0] prod;

    assign prod = er_q[j-1] * Factor;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ev_q[j] <= 1'b0;
      end else if (adv) begin
        ev_q[j] <= ev_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        er_q[j]  <= ef_q[j-1][NF-j] ? prod[64:32] : er_q[j-1];
        ef_q[j]  <= ef_q[j-1];
        en_q[j]  <= en_q[j-1];
        est_q[j] <= est_q[j-1];
        err_q[j] <= err_q[j-1];
      end
    end
  end

  // Stage 6: integer part of the exponent as a right shift.
  logic [32:0] e_6q;
  logic [1:0]  st_6q;
  logic [63:0] rr_6q;
  logic        v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (adv) begin
      v6_q <= ev_q[NF];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_6q  <= (en_q[NF] >= 17'd32) ? 33'd0 : (er_q[NF] >> en_q[NF][4:0]);
      st_6q <= est_q[NF];
      rr_6q <= err_q[NF];
    end
  end

  // Stage 7: prefactor times exponential, in two halves.
  logic [64:0] pl_7q, ph_7q;
  logic [32:0] e_7q;
  logic [1:0]  st_7q;
  logic        v7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (adv) begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pl_7q <= rr_6q[31:0] * e_6q;
      ph_7q <= rr_6q[63:32] * e_6q;
      e_7q  <= e_6q;
      st_7q <= st_6q;
    end
  end

  // Output register: combine or drop the prefactor, saturate and apply the status.
  logic [96:0]   w_d;
  logic [23:0]   prob_d;
  htp_pkg::out_t out_d, out_q;

  assign w_d = {ph_7q, 32'b0} + 97'(pl_7q);

  always_comb begin
    if (drop_q) begin
      prob_d = 24'(e_7q[32:16]);
    end else if (w_d[96:72] != '0) begin
      prob_d = '1;
    end else begin
      prob_d = w_d[71:48];
    end
    out_d.status = st_7q;
    out_d.probability = (st_7q == htp_pkg::ST_OK) ? prob_d : 24'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule
